@@ rtl/core/msgs_pkg.sv @@
// ----------------------------------------------------------------------------
// msgs_pkg
// Shared widths, register indexes, configuration record and divider stage
// record for the multi-stop gradient sampler.
// ----------------------------------------------------------------------------
package msgs_pkg;

  localparam int X_W         = 16;   // screen coordinate
  localparam int WIDTH_W     = 16;   // gradient period in pixels
  localparam int FRAC_W      = 16;   // fixed-point fraction bits
  localparam int CHAN_W      = 8;    // one color channel
  localparam int NUM_CHAN    = 3;
  localparam int COLOR_W     = CHAN_W * NUM_CHAN;
  localparam int COUNT_W     = 3;
  localparam int PALETTE_MAX = 5;
  localparam int SEG_IDX_W   = 2;    // segment index, at most PALETTE_MAX-2
  localparam int CFG_IDX_W   = 4;

  // One divider step retires one dividend bit: the coordinate bits, then the
  // fraction bits of the quotient.
  localparam int DIV_STEPS = X_W + FRAC_W;

  localparam logic [FRAC_W:0] FIXED_ONE = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_WIDTH     = 4'd0,
    REG_GRADIENT_OFFSET = 4'd1,
    REG_PALETTE_COUNT   = 4'd2,
    REG_COLOR_ZERO      = 4'd3,
    REG_COLOR_ONE       = 4'd4,
    REG_COLOR_TWO       = 4'd5,
    REG_COLOR_THREE     = 4'd6,
    REG_COLOR_FOUR      = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] total_width;
    logic [FRAC_W-1:0]  gradient_offset;
    logic [COUNT_W-1:0] palette_count;
    logic [COLOR_W-1:0] color_zero;
    logic [COLOR_W-1:0] color_one;
    logic [COLOR_W-1:0] color_two;
    logic [COLOR_W-1:0] color_three;
    logic [COLOR_W-1:0] color_four;
  } cfg_t;

  typedef struct packed {
    logic               neg;
    logic [X_W-1:0]     mag;
    logic [WIDTH_W-1:0] rem;
    logic [FRAC_W-1:0]  quo;
  } div_stage_t;

endpackage

@@ rtl/core/msgs_div_pipe.sv @@
// ----------------------------------------------------------------------------
// msgs_div_pipe
// Pipelined restoring divider: one quotient bit per stage. Produces the
// fraction bits of |x| * FIXED_ONE / total_width and the sign of x.
// ----------------------------------------------------------------------------
module msgs_div_pipe
  import msgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [X_W-1:0]     in_x,
  input  logic [WIDTH_W-1:0] divisor,
  output logic               out_valid,
  output div_stage_t         out_stage
);

  div_stage_t stage [DIV_STEPS+1];
  logic       vld   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // The magnitude of the most negative coordinate still fits unsigned.
  always_ff @(posedge clk) begin
    if (en) begin
      stage[0].neg <= in_x[X_W-1];
      stage[0].mag <= in_x[X_W-1] ? (~in_x + 1'b1) : in_x;
      stage[0].rem <= '0;
      stage[0].quo <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [WIDTH_W:0]   trial;
    logic [WIDTH_W:0]   diff;
    logic               take;
    div_stage_t         nxt;

    always_comb begin
      trial    = {stage[k].rem, stage[k].mag[X_W-1]};
      diff     = trial - {1'b0, divisor};
      take     = (trial >= {1'b0, divisor});
      nxt.neg  = stage[k].neg;
      nxt.mag  = stage[k].mag << 1;
      nxt.rem  = take ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      nxt.quo  = {stage[k].quo[FRAC_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[k+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_stage = stage[DIV_STEPS];

endmodule

@@ rtl/core/msgs_blend.sv @@
// ----------------------------------------------------------------------------
// msgs_blend
// Applies sign, zero width and phase to the quotient, picks the palette
// segment and blends the two neighboring stops per channel.
// ----------------------------------------------------------------------------
module msgs_blend
  import msgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  div_stage_t        in_stage,
  output logic              out_valid,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue
);

  localparam int SCALED_W = FRAC_W + COUNT_W;
  localparam int PROD_W   = CHAN_W + FRAC_W + 1;

  logic vld1, vld2, vld3, vld4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  // Stage 1: wrapped position. FIXED_ONE is a power of two, so the wrap is
  // plain modular arithmetic on the fraction bits.
  logic [FRAC_W-1:0] signed_quo;
  logic [FRAC_W-1:0] pos_raw;
  logic [FRAC_W-1:0] pos1;

  always_comb begin
    signed_quo = in_stage.neg ? (~in_stage.quo + 1'b1) : in_stage.quo;
    pos_raw    = (cfg.total_width == '0) ? '0 : signed_quo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1 <= pos_raw - cfg.gradient_offset;
    end
  end

  // Stage 2: segment choice.
  logic [COUNT_W-1:0]   count_sat;
  logic [COUNT_W-1:0]   segs;
  logic [SCALED_W-1:0]  scaled;
  logic [SEG_IDX_W-1:0] seg_idx;
  logic [COLOR_W-1:0]   col_a_next, col_b_next;
  logic [FRAC_W-1:0]    frac_next;
  logic [COLOR_W-1:0]   col_a, col_b;
  logic [FRAC_W-1:0]    frac2;

  always_comb begin
    count_sat = (cfg.palette_count > COUNT_W'(PALETTE_MAX)) ?
                COUNT_W'(PALETTE_MAX) : cfg.palette_count;
    segs      = count_sat - 1'b1;
    scaled    = SCALED_W'(pos1) * SCALED_W'(segs);
    seg_idx   = scaled[FRAC_W +: SEG_IDX_W];
    col_a_next = cfg.color_zero;
    col_b_next = cfg.color_one;
    frac_next  = pos1;
    if (count_sat > COUNT_W'(2)) begin
      frac_next = scaled[FRAC_W-1:0];
      unique case (seg_idx)
        2'd0: begin
          col_a_next = cfg.color_zero;
          col_b_next = cfg.color_one;
        end
        2'd1: begin
          col_a_next = cfg.color_one;
          col_b_next = cfg.color_two;
        end
        2'd2: begin
          col_a_next = cfg.color_two;
          col_b_next = cfg.color_three;
        end
        default: begin
          col_a_next = cfg.color_three;
          col_b_next = cfg.color_four;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_a <= col_a_next;
      col_b <= col_b_next;
      frac2 <= frac_next;
    end
  end

  // Stages 3 and 4: weighted products, then sum and drop the fraction.
  logic [FRAC_W:0]   weight_a;
  logic [CHAN_W-1:0] chan [NUM_CHAN];

  assign weight_a = FIXED_ONE - {1'b0, frac2};

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic [PROD_W-1:0] prod_a, prod_b;
    logic [PROD_W-1:0] sum;

    always_ff @(posedge clk) begin
      if (en) begin
        prod_a <= PROD_W'(col_a[c*CHAN_W +: CHAN_W]) * PROD_W'(weight_a);
        prod_b <= PROD_W'(col_b[c*CHAN_W +: CHAN_W]) * PROD_W'(frac2);
      end
    end

    assign sum = prod_a + prod_b;

    always_ff @(posedge clk) begin
      if (en) begin
        chan[c] <= sum[FRAC_W +: CHAN_W];
      end
    end
  end

  assign out_valid = vld4;
  assign red       = chan[0];
  assign green     = chan[1];
  assign blue      = chan[2];

endmodule

@@ rtl/core/multi_stop_gradient_sampler.sv @@
// ----------------------------------------------------------------------------
// multi_stop_gradient_sampler
// Repeating linear gradient: one RGB color per pixel coordinate.
// ----------------------------------------------------------------------------
// The sampler takes one pixel beat per clock and returns one color beat per
// clock. A pixel passes one input register, 32 stages of the pipelined
// position divider (one quotient bit per stage), and four stages of wrap,
// segment choice, multiply and sum. The last stage is the output register;
// when the output stalls, the whole pipeline holds.
// Configuration writes take effect at once and are meant for idle periods.
module multi_stop_gradient_sampler
  import msgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  // Pixel stream in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [X_W-1:0]       s_tdata,   // [15:0] screen_x
  // Color stream out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [COLOR_W-1:0]   m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOTAL_WIDTH:     cfg.total_width     <= cfg_data[WIDTH_W-1:0];
        REG_GRADIENT_OFFSET: cfg.gradient_offset <= cfg_data[FRAC_W-1:0];
        REG_PALETTE_COUNT:   cfg.palette_count   <= cfg_data[COUNT_W-1:0];
        REG_COLOR_ZERO:      cfg.color_zero      <= cfg_data;
        REG_COLOR_ONE:       cfg.color_one       <= cfg_data;
        REG_COLOR_TWO:       cfg.color_two       <= cfg_data;
        REG_COLOR_THREE:     cfg.color_three     <= cfg_data;
        REG_COLOR_FOUR:      cfg.color_four      <= cfg_data;
        default: ;
      endcase
    end
  end

  // All stages advance together unless a finished color is held at the output.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic              div_valid;
  div_stage_t        div_stage;
  logic [CHAN_W-1:0] red, green, blue;

  msgs_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_x      (s_tdata),
    .divisor   (cfg.total_width),
    .out_valid (div_valid),
    .out_stage (div_stage)
  );

  msgs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_stage  (div_stage),
    .out_valid (m_tvalid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_tdata = {blue, green, red};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-stop gradient sampler. A directed table
// covers reset colors, zero and widest periods, wrap at both coordinate
// limits, stop counts up to and past the palette size, an unmapped index.
// Random phases reprogram the block and stream pixels under random stalls
// on both sides; per channel each beat must match its table or model color.
// ----------------------------------------------------------------------------
module tb;
  import msgs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd13;

  localparam longint POS_ONE      = longint'(FIXED_ONE);
  localparam int     NUM_PHASES   = 9;
  localparam int     PHASE_PIXELS = 50;
  localparam int     LONG_HOLD    = 200;
  localparam int     DRAIN_LIMIT  = 5000;
  localparam int     TAIL_CYCLES  = 40;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;   // unused on pixel rows
    logic [COLOR_W-1:0]   data;
    logic [X_W-1:0]       x;
    bit                   typed;   // color column holds the expected result
    logic [COLOR_W-1:0]   color;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [X_W-1:0]       s_tdata;   // [15:0] screen_x
  logic                 m_tvalid;
  logic                 m_tready;
  logic [COLOR_W-1:0]   m_tdata;   // [7:0] red, [15:8] green, [23:16] blue

  // Shadow copy of the block's registers.
  logic [WIDTH_W-1:0] cur_width;
  logic [FRAC_W-1:0]  cur_offset;
  logic [COUNT_W-1:0] cur_count;
  logic [COLOR_W-1:0] cur_stop [PALETTE_MAX];

  logic [COLOR_W-1:0] pending_colors [$];
  int                 mismatches;
  int                 tx_gap_max;
  int                 rx_stall_max;
  int                 rx_hold_cycles;
  string              chan_name [NUM_CHAN] = '{"red", "green", "blue"};

  plan_row_t directed_plan [44] = '{
    // Every stop is black after reset.
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0000, 1'b1, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h7FFF, 1'b1, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h8000, 1'b1, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'hFFFF, 1'b1, 24'h000000},
    // Zero width pins the position at the start color.
    '{ROW_WRITE, REG_COLOR_ZERO,      24'h123456, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_COLOR_ONE,       24'hABCDEF, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h7FFF, 1'b1, 24'h123456},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h8000, 1'b1, 24'h123456},
    // Widest period; upper data bits must be dropped.
    '{ROW_WRITE, REG_TOTAL_WIDTH,     24'h5AFFFF, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h7FFF, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h8000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'hFFFF, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0001, 1'b0, 24'h000000},
    // A one-pixel period lands every coordinate on a whole period.
    '{ROW_WRITE, REG_TOTAL_WIDTH,     24'h000001, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0001, 1'b1, 24'h123456},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'hFFFF, 1'b1, 24'h123456},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h7FFF, 1'b1, 24'h123456},
    '{ROW_WRITE, REG_GRADIENT_OFFSET, 24'h00FFFF, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h8000, 1'b0, 24'h000000},
    // Multi-stop palette with saturated channel values.
    '{ROW_WRITE, REG_TOTAL_WIDTH,     24'h000100, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_GRADIENT_OFFSET, 24'h000000, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_COLOR_ZERO,      24'h000000, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_COLOR_ONE,       24'hFFFFFF, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_COLOR_TWO,       24'h00FF00, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_COLOR_THREE,     24'hFF0000, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_COLOR_FOUR,      24'h0000FF, 16'h0000, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_PALETTE_COUNT,   24'h000003, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0080, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h00FF, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_PALETTE_COUNT,   24'h000005, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0040, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h00C0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'hFFFF, 1'b0, 24'h000000},
    // Counts above the palette size saturate; smaller counts follow.
    '{ROW_WRITE, REG_PALETTE_COUNT,   24'h000007, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h00C0, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_PALETTE_COUNT,   24'h000004, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h00AA, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_PALETTE_COUNT,   24'h000001, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0080, 1'b0, 24'h000000},
    // Writes to an unmapped index change nothing.
    '{ROW_WRITE, REG_UNMAPPED,        24'hFFFFFF, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0080, 1'b0, 24'h000000},
    '{ROW_WRITE, REG_PALETTE_COUNT,   24'h000000, 16'h0000, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_UNMAPPED,        24'h000000, 16'h0000, 1'b1, 24'h000000}
  };

  multi_stop_gradient_sampler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] from,
                                                    logic [CHAN_W-1:0] to,
                                                    longint frac);
    if (frac <= 0) return from;
    return CHAN_W'((longint'(from) * (POS_ONE - frac) + longint'(to) * frac) / POS_ONE);
  endfunction

  function automatic logic [COLOR_W-1:0] gradient_color(logic [X_W-1:0] sx);
    longint             pos;
    longint             scaled;
    longint             frac;
    int                 count;
    int                 seg;
    logic [COLOR_W-1:0] lo;
    logic [COLOR_W-1:0] hi;
    logic [COLOR_W-1:0] rgb;
    pos = 0;
    if (cur_width != 0) pos = (longint'($signed(sx)) * POS_ONE) / longint'(cur_width);
    // Division and remainder truncate toward zero, so fold negatives back.
    pos = (pos - longint'(cur_offset)) % POS_ONE;
    if (pos < 0) pos += POS_ONE;
    count = (cur_count > PALETTE_MAX) ? PALETTE_MAX : int'(cur_count);
    if (count > 2) begin
      scaled = pos * (count - 1);
      seg    = int'(scaled / POS_ONE);
      frac   = scaled % POS_ONE;
      lo     = cur_stop[seg];
      hi     = cur_stop[seg + 1];
    end else begin
      lo   = cur_stop[0];
      hi   = cur_stop[1];
      frac = pos;
    end
    for (int k = 0; k < NUM_CHAN; k++) begin
      rgb[k*CHAN_W +: CHAN_W] = mix_channel(lo[k*CHAN_W +: CHAN_W], hi[k*CHAN_W +: CHAN_W],
                                            frac);
    end
    return rgb;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TOTAL_WIDTH:     cur_width  = data[WIDTH_W-1:0];
      REG_GRADIENT_OFFSET: cur_offset = data[FRAC_W-1:0];
      REG_PALETTE_COUNT:   cur_count  = data[COUNT_W-1:0];
      REG_COLOR_ZERO, REG_COLOR_ONE, REG_COLOR_TWO, REG_COLOR_THREE, REG_COLOR_FOUR:
        cur_stop[idx - REG_COLOR_ZERO] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [X_W-1:0] x, input bit typed,
                            input logic [COLOR_W-1:0] typed_color);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_colors.push_back(typed ? typed_color : gradient_color(x));
  endtask

  // Stops offering pixels and waits until every pending color has come out.
  task automatic wait_idle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_colors.size() != 0) begin
      report_mismatch($sformatf("%0d color beats never arrived", pending_colors.size()));
      pending_colors.delete();
    end
  endtask

  // Output side: per-beat random stall, plus an optional long hold-off.
  initial begin : color_sink
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : color_check
    logic [COLOR_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("color beat %h with no pixel pending", m_tdata));
      end else begin
        want = pending_colors.pop_front();
        for (int k = 0; k < NUM_CHAN; k++) begin
          if (m_tdata[k*CHAN_W +: CHAN_W] !== want[k*CHAN_W +: CHAN_W]) begin
            report_mismatch($sformatf("%s got %h, want %h", chan_name[k],
                                      m_tdata[k*CHAN_W +: CHAN_W],
                                      want[k*CHAN_W +: CHAN_W]));
          end
        end
      end
    end
  end

  initial begin : pixel_source
    logic [WIDTH_W-1:0] w;
    int                 span;
    int                 xv;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_TOTAL_WIDTH;
    cfg_data       <= '0;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    cur_width      = '0;
    cur_offset     = '0;
    cur_count      = '0;
    for (int i = 0; i < PALETTE_MAX; i++) cur_stop[i] = '0;
    mismatches     = 0;
    tx_gap_max     = 15;
    rx_stall_max   = 15;
    rx_hold_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        wait_idle();
        program_reg(directed_plan[i].index, directed_plan[i].data);
      end else begin
        send_pixel(directed_plan[i].x, directed_plan[i].typed, directed_plan[i].color);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph == 0) begin
        // Extremes: widest period, largest phase, saturated stop count.
        program_reg(REG_TOTAL_WIDTH,     24'hFFFFFF);
        program_reg(REG_GRADIENT_OFFSET, 24'hFFFFFF);
        program_reg(REG_PALETTE_COUNT,   24'hFFFFFF);
        program_reg(REG_COLOR_ZERO,      24'hFFFFFF);
        program_reg(REG_COLOR_ONE,       24'h000000);
        program_reg(REG_COLOR_TWO,       24'hFFFFFF);
        program_reg(REG_COLOR_THREE,     24'h000000);
        program_reg(REG_COLOR_FOUR,      24'hFFFFFF);
      end else begin
        case ($urandom_range(0, 9))
          0:          w = '0;
          1, 2:       w = WIDTH_W'($urandom_range(1, 16));
          3, 4, 5, 6: w = WIDTH_W'($urandom_range(17, 2000));
          default:    w = WIDTH_W'($urandom_range(2001, 65535));
        endcase
        if (ph == 1) w = '0;
        program_reg(REG_TOTAL_WIDTH, {8'($urandom), w});
        program_reg(REG_GRADIENT_OFFSET, COLOR_W'($urandom));
        program_reg(REG_PALETTE_COUNT, COLOR_W'($urandom));
        for (int c = 0; c < PALETTE_MAX; c++) begin
          program_reg(CFG_IDX_W'(REG_COLOR_ZERO + c), COLOR_W'($urandom));
        end
        if ($urandom_range(0, 2) == 0) program_reg(REG_UNMAPPED, COLOR_W'($urandom));
      end

      case (ph % 4)
        0: begin tx_gap_max = 15; rx_stall_max = 15; end
        1: begin tx_gap_max = 0;  rx_stall_max = 15; end
        2: begin tx_gap_max = 15; rx_stall_max = 0;  end
        default: begin tx_gap_max = 0; rx_stall_max = 0; end
      endcase
      // Back-to-back pixels against a long output hold fill the pipeline.
      if (ph == 5) rx_hold_cycles = LONG_HOLD;

      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (ph == 6 && n == PHASE_PIXELS / 2) wait_idle();
        span = (cur_width == 0) ? 64 : 2 * int'(cur_width);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: xv = $urandom_range(0, 65535);
          4, 5, 6:    xv = $urandom_range(0, 2 * span) - span;
          7:          xv = int'(cur_width) * ($urandom_range(0, 6) - 3) + $urandom_range(0, 2) - 1;
          8:          xv = 32'h7FFF + $urandom_range(0, 1);
          default:    xv = $urandom_range(0, 16) - 8;
        endcase
        send_pixel(X_W'(xv), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_colors.size() != 0) begin
      report_mismatch($sformatf("%0d color beats left over", pending_colors.size()));
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/msgs_pkg.sv
rtl/core/msgs_div_pipe.sv
rtl/core/msgs_blend.sv
rtl/core/multi_stop_gradient_sampler.sv
tb/tb.sv
